// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/wmd_pkg.sv -----
// ----------------------------------------------------------------------------
// wmd_pkg
// Types, constants and helpers for the window motion detector.
// ----------------------------------------------------------------------------
package wmd_pkg;

   localparam int WIN_LEN    = 6;
   localparam int FRAC_BITS  = 4;
   localparam int COORD_W    = 16;
   localparam int THR_W      = 16;
   localparam int IDX_W      = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
   localparam int CNT_W      = $clog2(WIN_LEN + 1);
   localparam int SQ_W       = 2 * COORD_W;
   localparam int DIST_W     = SQ_W + 1;
   localparam int CSR_IDX_W  = 1;

   // 50 pixels and 140*pi pixels in coordinate units
   localparam logic [THR_W-1:0] LOW_RESET  = THR_W'(50 << FRAC_BITS);
   localparam logic [THR_W-1:0] HIGH_RESET =
      THR_W'(((64'd4398230 << FRAC_BITS) + 64'd5000) / 64'd10000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW  = 1'b0,
      CSR_HIGH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      point_type        data;
   } win_wr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_LO,
      ST_SQ_HI,
      ST_CAP_HI,
      ST_RD,
      ST_DX,
      ST_DY,
      ST_ACC,
      ST_WR
   } state_type;

   // Ring index a + b, both operands below WIN_LEN
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
      if (sum >= (CNT_W + 1)'(WIN_LEN)) begin
         sum = sum - (CNT_W + 1)'(WIN_LEN);
      end
      return sum[IDX_W-1:0];
   endfunction

   // |a - b| always fits in COORD_W unsigned bits
   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] diff;
      diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      if (diff[COORD_W]) begin
         diff = -diff;
      end
      return diff[COORD_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/wmd_sqr.sv -----
// ----------------------------------------------------------------------------
// wmd_sqr
// Shared squaring unit: registered unsigned square of one operand per cycle.
// ----------------------------------------------------------------------------
module wmd_sqr
   import wmd_pkg::*;
(
   input  logic               clock,
   input  logic [COORD_W-1:0] op,
   output logic [SQ_W-1:0]    prod_ff
);

   logic [SQ_W-1:0] prod_in;

   assign prod_in = SQ_W'(op) * SQ_W'(op);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- hw/rtl/wmd_win.sv -----
// ----------------------------------------------------------------------------
// wmd_win
// Point window storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wmd_win
   import wmd_pkg::*;
(
   input  logic             clock,
   input  win_wr_type       wr,
   input  logic [IDX_W-1:0] rd_addr,
   output point_type        rd_data_ff
);

   point_type mem [WIN_LEN];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/window_motion_detector.sv -----
// ----------------------------------------------------------------------------
// window_motion_detector
// Flags motion when the farthest stored point lies strictly inside a band.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel carries one point (signed Q12.4 x and y) per beat; req_stall
//    is high whenever an item is in flight, so one item is worked at a time.
//  - rsp channel returns one moving flag per request beat, in order.
//  - csr port writes low_threshold (index 0) or high_threshold (index 1);
//    write only while the block is idle.
// Sequence: an accepted item first squares the thresholds (low, high, then
//  capture of the high square), then for each of the N points already in
//  the window (0..6) reads it, squares dx and dy and accumulates, and then
//  stores the point and posts the result; the next item is taken once the
//  block is back in idle. The single shared squaring unit sets this order.
// Reset: clears the window fill count, ring pointer and pending result, and
//  loads the thresholds with 800 and 7037.
// Stall: the result is held in an output register while rsp_stall is high;
//  the next item can be accepted meanwhile but its result waits until the
//  register is free.
// ----------------------------------------------------------------------------
module window_motion_detector
   import wmd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_moving,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [THR_W-1:0]          csr_wdata
);

`include "assert_macros.svh"

   state_type        state_ff, state_in;
   point_type        point_ff, point_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [SQ_W-1:0]  lo2_ff, lo2_in;
   logic [SQ_W-1:0]  hi2_ff, hi2_in;
   logic [SQ_W-1:0]  sqx_ff, sqx_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [THR_W-1:0] low_thr_ff, low_thr_in;
   logic [THR_W-1:0] high_thr_ff, high_thr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_moving_ff, rsp_moving_in;

   logic             req_take;
   logic             out_free;
   logic [COORD_W-1:0] sq_op;
   logic [SQ_W-1:0]  prod;
   logic [IDX_W-1:0] rd_addr;
   point_type        rd_data;
   win_wr_type       win_wr;
   logic [DIST_W-1:0] dist_sq;

   wmd_sqr u_sqr (
      .clock   (clock),
      .op      (sq_op),
      .prod_ff (prod)
   );

   wmd_win u_win (
      .clock      (clock),
      .wr         (win_wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_moving = rsp_moving_ff;
   assign dist_sq    = DIST_W'(sqx_ff) + DIST_W'(prod);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SQ_LO;
         ST_SQ_LO:  state_in = ST_SQ_HI;
         ST_SQ_HI:  state_in = ST_CAP_HI;
         ST_CAP_HI: state_in = (fill_ff == '0) ? ST_WR : ST_RD;
         ST_RD:     state_in = ST_DX;
         ST_DX:     state_in = ST_DY;
         ST_DY:     state_in = ST_ACC;
         ST_ACC:    state_in = ((cnt_ff + CNT_W'(1)) == fill_ff) ? ST_WR : ST_RD;
         ST_WR:     if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Unit operands and window ports
   always_comb begin
      sq_op       = '0;
      rd_addr     = ring_add(oldest_ff, cnt_ff);
      win_wr.en   = 1'b0;
      win_wr.addr = (fill_ff == CNT_W'(WIN_LEN)) ? oldest_ff : ring_add(oldest_ff, fill_ff);
      win_wr.data = point_ff;
      case (state_ff)
         ST_SQ_LO: sq_op = low_thr_ff;
         ST_SQ_HI: sq_op = high_thr_ff;
         ST_DX:    sq_op = abs_diff(point_ff.x, rd_data.x);
         ST_DY:    sq_op = abs_diff(point_ff.y, rd_data.y);
         ST_WR:    win_wr.en = out_free;
         default:  sq_op = '0;
      endcase
   end

   // Datapath and bookkeeping
   always_comb begin
      point_in      = point_ff;
      cnt_in        = cnt_ff;
      fill_in       = fill_ff;
      oldest_in     = oldest_ff;
      lo2_in        = lo2_ff;
      hi2_in        = hi2_ff;
      sqx_in        = sqx_ff;
      best_in       = best_ff;
      low_thr_in    = low_thr_ff;
      high_thr_in   = high_thr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_moving_in = rsp_moving_ff;

      if (csr_write && (csr_index == CSR_LOW)) begin
         low_thr_in = csr_wdata;
      end
      if (csr_write && (csr_index == CSR_HIGH)) begin
         high_thr_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               point_in.x = req_point_x;
               point_in.y = req_point_y;
               cnt_in     = '0;
               best_in    = '0;
            end
         end
         ST_SQ_HI:  lo2_in = prod;
         ST_CAP_HI: hi2_in = prod;
         ST_DY:     sqx_in = prod;
         ST_ACC: begin
            if (dist_sq > best_ff) best_in = dist_sq;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_WR: begin
            if (out_free) begin
               // Append until full, then overwrite the oldest and advance
               if (fill_ff == CNT_W'(WIN_LEN)) begin
                  oldest_in = ring_add(oldest_ff, CNT_W'(1));
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_moving_in = (best_ff > DIST_W'(lo2_ff)) && (best_ff < DIST_W'(hi2_ff));
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         low_thr_ff   <= LOW_RESET;
         high_thr_ff  <= HIGH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         low_thr_ff   <= low_thr_in;
         high_thr_ff  <= high_thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff      <= point_in;
      lo2_ff        <= lo2_in;
      hi2_ff        <= hi2_in;
      sqx_ff        <= sqx_in;
      best_ff       <= best_in;
      rsp_moving_ff <= rsp_moving_in;
   end

   `ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= CNT_W'(WIN_LEN), "fill count overflow")
   `ASSERT_IMPL(a_ring_full, clock, reset, oldest_ff != '0,
      fill_ff == CNT_W'(WIN_LEN), "ring moved before window full")
   `ASSERT_IMPL(a_acc_range, clock, reset, state_ff == ST_ACC,
      cnt_ff < fill_ff, "walk beyond stored points")
   `ASSERT_NEXT(a_rsp_source, clock, reset, !rsp_valid_ff && state_ff != ST_WR,
      !rsp_valid_ff, "result posted outside write step")

endmodule
